// ===== hdl/vca_pkg.sv =====
// ----------------------------------------------------------------------------
// vca_pkg: shared types and constants of the virtual channel link arbiter
// Field widths, payload layout, result codes, register indexes and the
// status record that each channel lane hands to the sequencer.
// ----------------------------------------------------------------------------
package vca_pkg;

   // Field widths of one transfer attempt and of one result.
   localparam int ELAPSED_W = 8;
   localparam int CH_FIELD_W = 2;
   localparam int BYTES_W = 11;
   localparam int OCC_W = 16;
   localparam int MASK_W = 4;
   localparam int OUTCOME_W = 3;
   localparam int DELAY_W = 11;

   // Configuration register widths.
   localparam int BW_W = 7;
   localparam int CAP_W = 16;
   localparam int CIU_W = 3;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Retry delays saturate; a time difference at or above this gives the maximum.
   localparam logic [DELAY_W-1:0] DELAY_MAX = 11'd2047;
   localparam int DELAY_SAT_DIFF = 2046;

   // Register values after reset.
   localparam logic [BW_W-1:0] BW_RESET = 7'd8;
   localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;
   localparam logic [CIU_W-1:0] CIU_RESET = 3'd1;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_SENT        = 3'd0,
      OUT_NOT_HEAD    = 3'd1,
      OUT_LINK_BUSY   = 3'd2,
      OUT_ARB_LOST    = 3'd3,
      OUT_DEST_BUSY   = 3'd4,
      OUT_DEST_FULL   = 3'd5,
      OUT_BAD_CHANNEL = 3'd6
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINK_BW    = 2'd0,
      CSR_DEST_BYTES = 2'd1,
      CSR_CHANNELS   = 2'd2
   } csr_index_type;

   // What one channel lane reports about its own channel for the current cycle.
   typedef struct packed {
      logic                elig;
      logic                write_ge;
      logic [DELAY_W-1:0]  write_delay;
   } lane_status_type;

endpackage

// ===== hdl/link_vc_arbiter_transfer.sv =====
// ----------------------------------------------------------------------------
// link_vc_arbiter_transfer: round-robin virtual channel link arbiter
// Judges one transfer attempt of a source virtual channel head packet across
// a shared link and keeps the link, channel and arbitration timing state.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                         Payload
//  req_      in         req_tvalid/tready/tdata       one transfer attempt
//  rsp_      out        rsp_tvalid/tready/tdata       one result per attempt
//  csr_      in         csr_valid/ready/index/wdata   register write
//
// One attempt is handled at a time. A refused attempt passes the compare,
// arbitration and decide steps; a granted nonempty transfer also waits on
// the serial divider, which forms the latency one bit per cycle. After a
// change of channels_in_use the round-robin start position may need
// repeated reduction in the compare step. Reset is synchronous and brings the
// cycle count to one and all busy times to zero. A result held on rsp_ does
// not block the next attempt from being taken; it only delays the one after.
//
module link_vc_arbiter_transfer import vca_pkg::*; #(
   parameter int MAX_CHANNELS = 4,
   parameter int TIME_BITS    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // Attempt, from bit 0 up: cycles_elapsed[7:0], request_channel[9:8],
   // at_head[10], packet_bytes[21:11], dest_occupancy[37:22],
   // head_present_mask[41:38], head_ready_mask[45:42], zero fill[47:46].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Result, from bit 0 up: outcome[2:0], retry_delay[13:3],
   // transfer_latency[24:14], granted_channel[26:25], grant_valid[27],
   // zero fill[31:28].
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Register writes: index 0 link_bandwidth, 1 dest_buffer_bytes,
   // 2 channels_in_use.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // CNT_W holds a channel count up to MAX_CHANNELS, IDX_W a channel index.
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W = CNT_W + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_ARB,
      S_DECIDE,
      S_DIV,
      S_END,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [BW_W-1:0]  bw_ff, bw_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CIU_W-1:0] ciu_ff, ciu_in;

   // Timing and arbitration state.
   logic [TIME_BITS-1:0] cycle_ff, cycle_in;
   logic [TIME_BITS-1:0] link_busy_ff, link_busy_in;
   logic [IDX_W-1:0]     last_granted_ff, last_granted_in;
   logic [TIME_BITS-1:0] decided_cycle_ff, decided_cycle_in;
   logic [CNT_W-1:0]     decided_ch_ff, decided_ch_in;
   logic [CNT_W-1:0]     start_ff, start_in;

   // The attempt being judged.
   logic [CH_FIELD_W-1:0] ch_ff, ch_in;
   logic                  head_ff, head_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [MASK_W-1:0]     present_ff, present_in;
   logic [MASK_W-1:0]     ready_ff, ready_in;

   // Checks registered in the compare step.
   logic               link_ge_ff, link_ge_in;
   logic [DELAY_W-1:0] link_delay_ff, link_delay_in;
   logic               memo_hit_ff, memo_hit_in;
   logic               full_ff, full_in;
   logic               bad_ff, bad_in;

   // Result being built and the output register.
   outcome_type           res_outcome_ff, res_outcome_in;
   logic [DELAY_W-1:0]    res_delay_ff, res_delay_in;
   logic [BYTES_W-1:0]    res_lat_ff, res_lat_in;
   logic [CH_FIELD_W-1:0] res_gch_ff, res_gch_in;
   logic                  res_gv_ff, res_gv_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Lanes, merge and divider.
   lane_status_type         lane_status [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] lane_elig;
   logic [MAX_CHANNELS-1:0] lane_upd;
   logic [TIME_BITS-1:0]    end_time;
   logic                    pick_valid_ff;
   logic [IDX_W-1:0]        pick_idx_ff;
   logic                    div_start;
   logic                    div_done;
   logic [BYTES_W-1:0]      div_quotient;
   logic [BYTES_W-1:0]      div_dividend;
   logic [BW_W-1:0]         div_divisor;

   // Decode and selection helpers.
   logic [CNT_W-1:0]     n_active;
   logic [TIME_BITS-1:0] link_diff;
   logic                 sel_write_ge;
   logic [DELAY_W-1:0]   sel_write_delay;
   logic                 arb_valid;
   logic [IDX_W-1:0]     arb_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A channel count of zero acts as one; a count above the lane count is clamped.
   always_comb begin
      if (ciu_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (CMP_W'(ciu_ff) > CMP_W'(MAX_CHANNELS)) begin
         n_active = CNT_W'(MAX_CHANNELS);
      end else begin
         n_active = CNT_W'(ciu_ff);
      end
   end

   // The transfer holds the link and both channel sides through its last cycle.
   assign end_time = cycle_ff + TIME_BITS'(res_lat_ff) - TIME_BITS'(1);

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic lane_present;
      logic lane_ready;

      // Channels beyond the mask width never hold a head packet.
      if (c < MASK_W) begin : g_masked
         assign lane_present = present_ff[c];
         assign lane_ready   = ready_ff[c];
      end else begin : g_unmasked
         assign lane_present = 1'b0;
         assign lane_ready   = 1'b0;
      end

      assign lane_upd[c]  = (state_ff == S_END) && (int'(ch_ff) == c);
      assign lane_elig[c] = lane_status[c].elig;

      vca_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .cycle_now (cycle_ff),
         .upd_en    (lane_upd[c]),
         .upd_end   (end_time),
         .present   (lane_present),
         .ready     (lane_ready),
         .active    (CNT_W'(c) < n_active),
         .status_ff (lane_status[c])
      );
   end

   vca_merge #(
      .N     (MAX_CHANNELS),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .elig          (lane_elig),
      .start         (start_ff),
      .pick_valid_ff (pick_valid_ff),
      .pick_idx_ff   (pick_idx_ff)
   );

   // The divider divides packet bytes less one by the bandwidth, a bandwidth of zero acting as one.
   assign div_dividend = bytes_ff - 11'd1;
   assign div_divisor  = (bw_ff == '0) ? BW_W'(1) : bw_ff;

   vca_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor     (div_divisor),
      .done_ff     (div_done),
      .quotient_ff (div_quotient)
   );

   // Write side of the requesting channel, picked from its lane.
   always_comb begin
      sel_write_ge    = 1'b0;
      sel_write_delay = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (int'(ch_ff) == c) begin
            sel_write_ge    = lane_status[c].write_ge;
            sel_write_delay = lane_status[c].write_delay;
         end
      end
   end

   // Arbitration is decided once per cycle: a second attempt in the same
   // cycle reuses the remembered winner instead of the fresh lane pick.
   always_comb begin
      if (memo_hit_ff) begin
         arb_valid = (decided_ch_ff != '0);
         arb_idx   = IDX_W'(decided_ch_ff - CNT_W'(1));
      end else begin
         arb_valid = pick_valid_ff;
         arb_idx   = pick_idx_ff;
      end
   end

   assign link_diff = link_busy_ff - cycle_ff;

   always_comb begin
      state_in         = state_ff;
      bw_in            = bw_ff;
      cap_in           = cap_ff;
      ciu_in           = ciu_ff;
      cycle_in         = cycle_ff;
      link_busy_in     = link_busy_ff;
      last_granted_in  = last_granted_ff;
      decided_cycle_in = decided_cycle_ff;
      decided_ch_in    = decided_ch_ff;
      start_in         = start_ff;
      ch_in            = ch_ff;
      head_in          = head_ff;
      bytes_in         = bytes_ff;
      occ_in           = occ_ff;
      present_in       = present_ff;
      ready_in         = ready_ff;
      link_ge_in       = link_ge_ff;
      link_delay_in    = link_delay_ff;
      memo_hit_in      = memo_hit_ff;
      full_in          = full_ff;
      bad_in           = bad_ff;
      res_outcome_in   = res_outcome_ff;
      res_delay_in     = res_delay_ff;
      res_lat_in       = res_lat_ff;
      res_gch_in       = res_gch_ff;
      res_gv_in        = res_gv_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_tready;
      rsp_data_in      = rsp_data_ff;
      div_start        = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LINK_BW:    bw_in  = csr_wdata[BW_W-1:0];
            CSR_DEST_BYTES: cap_in = csr_wdata[CAP_W-1:0];
            CSR_CHANNELS:   ciu_in = csr_wdata[CIU_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cycle_in   = cycle_ff + TIME_BITS'(req_tdata[7:0]);
               ch_in      = req_tdata[9:8];
               head_in    = req_tdata[10];
               bytes_in   = req_tdata[21:11];
               occ_in     = req_tdata[37:22];
               present_in = req_tdata[41:38];
               ready_in   = req_tdata[45:42];
               start_in   = CNT_W'(last_granted_ff) + CNT_W'(1);
               state_in   = S_CMP;
            end
         end

         S_CMP: begin
            link_ge_in = (link_busy_ff >= cycle_ff);
            if (link_diff >= TIME_BITS'(DELAY_SAT_DIFF)) begin
               link_delay_in = DELAY_MAX;
            end else begin
               link_delay_in = link_diff[DELAY_W-1:0] + 11'd1;
            end
            memo_hit_in = (decided_cycle_ff == cycle_ff);
            full_in     = ({1'b0, occ_ff} + (OCC_W + 1)'(bytes_ff)) > {1'b0, cap_ff};
            bad_in      = (CMP_W'(ch_ff) >= CMP_W'(n_active));
            // Reduce the round-robin start below the channel count.
            if (start_ff >= n_active) begin
               start_in = start_ff - n_active;
            end else begin
               state_in = S_ARB;
            end
         end

         S_ARB: begin
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            res_delay_in = '0;
            res_lat_in   = '0;
            res_gch_in   = '0;
            res_gv_in    = 1'b0;
            state_in     = S_DONE;
            if (bad_ff) begin
               res_outcome_in = OUT_BAD_CHANNEL;
            end else if (!head_ff) begin
               res_outcome_in = OUT_NOT_HEAD;
            end else if (link_ge_ff) begin
               res_outcome_in = OUT_LINK_BUSY;
               res_delay_in   = link_delay_ff;
            end else begin
               if (!memo_hit_ff) begin
                  decided_cycle_in = cycle_ff;
                  decided_ch_in    = pick_valid_ff ?
                                     CNT_W'(pick_idx_ff) + CNT_W'(1) : '0;
                  if (pick_valid_ff) begin
                     last_granted_in = pick_idx_ff;
                  end
               end
               res_gv_in  = arb_valid;
               res_gch_in = arb_valid ? CH_FIELD_W'(arb_idx) : '0;
               if (!(arb_valid && (CMP_W'(arb_idx) == CMP_W'(ch_ff)))) begin
                  res_outcome_in = OUT_ARB_LOST;
                  res_delay_in   = 11'd1;
               end else if (sel_write_ge) begin
                  res_outcome_in = OUT_DEST_BUSY;
                  res_delay_in   = sel_write_delay;
               end else if (full_ff) begin
                  res_outcome_in = OUT_DEST_FULL;
               end else begin
                  res_outcome_in = OUT_SENT;
                  // An empty packet still holds the link, with the latency of a one-byte packet.
                  if (bytes_ff == '0) begin
                     res_lat_in = 11'd1;
                     state_in   = S_END;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               res_lat_in = div_quotient + 11'd1;
               state_in   = S_END;
            end
         end

         S_END: begin
            link_busy_in = end_time;
            state_in     = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, res_gv_ff, res_gch_ff, res_lat_ff,
                               res_delay_ff, res_outcome_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_in_unused_guard: begin
      end
      ch_ff          <= ch_in;
      head_ff        <= head_in;
      bytes_ff       <= bytes_in;
      occ_ff         <= occ_in;
      present_ff     <= present_in;
      ready_ff       <= ready_in;
      link_ge_ff     <= link_ge_in;
      link_delay_ff  <= link_delay_in;
      memo_hit_ff    <= memo_hit_in;
      full_ff        <= full_in;
      bad_ff         <= bad_in;
      res_outcome_ff <= res_outcome_in;
      res_delay_ff   <= res_delay_in;
      res_lat_ff     <= res_lat_in;
      res_gch_ff     <= res_gch_in;
      res_gv_ff      <= res_gv_in;
      rsp_data_ff    <= rsp_data_in;
      start_ff       <= start_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         bw_ff            <= BW_RESET;
         cap_ff           <= CAP_RESET;
         ciu_ff           <= CIU_RESET;
         cycle_ff         <= TIME_BITS'(1);
         link_busy_ff     <= '0;
         last_granted_ff  <= '0;
         decided_cycle_ff <= '0;
         decided_ch_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         bw_ff            <= bw_in;
         cap_ff           <= cap_in;
         ciu_ff           <= ciu_in;
         cycle_ff         <= cycle_in;
         link_busy_ff     <= link_busy_in;
         last_granted_ff  <= last_granted_in;
         decided_cycle_ff <= decided_cycle_in;
         decided_ch_ff    <= decided_ch_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/vca_lane.sv =====
// ----------------------------------------------------------------------------
// vca_lane: one virtual channel lane
// Holds the read and write busy times of its channel and reports, registered,
// whether the channel may win arbitration and how long its write side is busy.
// ----------------------------------------------------------------------------
module vca_lane import vca_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [TIME_BITS-1:0] cycle_now,
   input  logic                 upd_en,
   input  logic [TIME_BITS-1:0] upd_end,
   input  logic                 present,
   input  logic                 ready,
   input  logic                 active,
   output lane_status_type      status_ff
);

   logic [TIME_BITS-1:0] read_busy_ff;
   logic [TIME_BITS-1:0] read_busy_in;
   logic [TIME_BITS-1:0] write_busy_ff;
   logic [TIME_BITS-1:0] write_busy_in;
   logic [TIME_BITS-1:0] write_diff;
   lane_status_type      status_in;

   always_comb begin
      read_busy_in  = upd_en ? upd_end : read_busy_ff;
      write_busy_in = upd_en ? upd_end : write_busy_ff;
      write_diff    = write_busy_ff - cycle_now;

      // A channel whose read side is still busy this cycle is skipped.
      status_in.elig     = present & ready & active & (read_busy_ff < cycle_now);
      status_in.write_ge = (write_busy_ff >= cycle_now);
      if (write_diff >= TIME_BITS'(DELAY_SAT_DIFF)) begin
         status_in.write_delay = DELAY_MAX;
      end else begin
         status_in.write_delay = write_diff[DELAY_W-1:0] + 11'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_busy_ff  <= '0;
         write_busy_ff <= '0;
         status_ff     <= '0;
      end else begin
         read_busy_ff  <= read_busy_in;
         write_busy_ff <= write_busy_in;
         status_ff     <= status_in;
      end
   end

endmodule

// ===== hdl/vca_merge.sv =====
// ----------------------------------------------------------------------------
// vca_merge: round-robin merge of the lane results
// Picks the first eligible lane at or after the start position, wrapping to
// the lowest eligible lane below it, and registers the choice.
// ----------------------------------------------------------------------------
module vca_merge import vca_pkg::*; #(
   parameter int N     = 4,
   parameter int CNT_W = 3,
   parameter int IDX_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [N-1:0]     elig,
   input  logic [CNT_W-1:0] start,
   output logic             pick_valid_ff,
   output logic [IDX_W-1:0] pick_idx_ff
);

   logic             hi_found;
   logic             lo_found;
   logic [IDX_W-1:0] hi_idx;
   logic [IDX_W-1:0] lo_idx;
   logic             pick_valid_in;
   logic [IDX_W-1:0] pick_idx_in;

   // Scanning downward leaves the lowest matching lane in each half.
   always_comb begin
      hi_found = 1'b0;
      lo_found = 1'b0;
      hi_idx   = '0;
      lo_idx   = '0;
      for (int c = N - 1; c >= 0; c--) begin
         if (elig[c]) begin
            if (CNT_W'(c) >= start) begin
               hi_found = 1'b1;
               hi_idx   = IDX_W'(c);
            end else begin
               lo_found = 1'b1;
               lo_idx   = IDX_W'(c);
            end
         end
      end
      pick_valid_in = hi_found | lo_found;
      pick_idx_in   = hi_found ? hi_idx : lo_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_valid_ff <= 1'b0;
         pick_idx_ff   <= '0;
      end else begin
         pick_valid_ff <= pick_valid_in;
         pick_idx_ff   <= pick_idx_in;
      end
   end

endmodule

// ===== hdl/vca_div.sv =====
// ----------------------------------------------------------------------------
// vca_div: serial divider for the transfer latency
// Restoring division of packet size less one by the link bandwidth, one
// quotient bit per cycle, and a one-cycle done pulse when it is ready.
// ----------------------------------------------------------------------------
module vca_div import vca_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [BYTES_W-1:0] dividend,
   input  logic [BW_W-1:0]    divisor,
   output logic               done_ff,
   output logic [BYTES_W-1:0] quotient_ff
);

   localparam int STEP_W = $clog2(BYTES_W + 1);

   logic               busy_ff;
   logic               busy_in;
   logic               done_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [BW_W-1:0]    rem_ff;
   logic [BW_W-1:0]    rem_in;
   logic [BW_W-1:0]    divisor_ff;
   logic [BW_W-1:0]    divisor_in;
   logic [BYTES_W-1:0] quotient_in;
   logic [BW_W:0]      trial;
   logic [BW_W:0]      trial_diff;
   logic               trial_ge;

   always_comb begin
      // The quotient register shifts dividend bits out at the top and
      // quotient bits in at the bottom.
      trial      = {rem_ff, quotient_ff[BYTES_W-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      trial_ge   = (trial >= {1'b0, divisor_ff});

      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      quotient_in = quotient_ff;

      if (start) begin
         busy_in     = 1'b1;
         step_in     = STEP_W'(BYTES_W);
         rem_in      = '0;
         divisor_in  = divisor;
         quotient_in = dividend;
      end else if (busy_ff) begin
         rem_in      = trial_ge ? trial_diff[BW_W-1:0] : trial[BW_W-1:0];
         quotient_in = {quotient_ff[BYTES_W-2:0], trial_ge};
         step_in     = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      quotient_ff <= quotient_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

endmodule

// ===== hdl/vca_checker.sv =====
// ----------------------------------------------------------------------------
// vca_checker: port-level checks of the virtual channel link arbiter
// Watches the result stream and the attempt handshake and flags results
// whose fields disagree with their outcome code.
// ----------------------------------------------------------------------------
module vca_checker import vca_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_DATA_W-1:0]  req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [OUTCOME_W-1:0]  outcome;
   logic [DELAY_W-1:0]    delay;
   logic [BYTES_W-1:0]    latency;
   logic [CH_FIELD_W-1:0] gch;
   logic                  gv;

   assign outcome = rsp_tdata[2:0];
   assign delay   = rsp_tdata[13:3];
   assign latency = rsp_tdata[24:14];
   assign gch     = rsp_tdata[26:25];
   assign gv      = rsp_tdata[27];

   // A result waiting for the sink keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one attempt is in flight: a taken attempt closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("attempt taken while another is in flight");

   // A sent packet won arbitration, waits for nothing and occupies the link.
   a_sent_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (outcome == OUT_SENT) |-> gv && (latency != '0) && (delay == '0))
      else $error("sent result with inconsistent fields");

   // Refusals decided before arbitration carry no grant and no latency.
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (outcome == OUT_NOT_HEAD || outcome == OUT_LINK_BUSY ||
                     outcome == OUT_BAD_CHANNEL)
      |-> !gv && (gch == '0) && (latency == '0))
      else $error("grant reported without arbitration");

   // A lost arbitration always retries in the next cycle.
   a_arb_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (outcome == OUT_ARB_LOST) |-> (delay == 11'd1) && (latency == '0))
      else $error("lost arbitration with wrong delay");

endmodule

bind link_vc_arbiter_transfer vca_checker u_vca_checker (.*);

// ===== verif/tb_link_vc_arbiter_transfer.sv =====
// ----------------------------------------------------------------------------
// tb_link_vc_arbiter_transfer: self-checking bench of the VC link arbiter
// Streams transfer attempts into the arbiter, predicts every verdict with a
// cycle-level model of its timing state and compares each result field by
// field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_link_vc_arbiter_transfer;
   import vca_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_VC      = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 140;

   // Index 3 has no register behind it; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // One transfer attempt, declared from the top bit down so that
   // cycles_elapsed lands in bit 0 of req_tdata.
   typedef struct packed {
      logic [MASK_W-1:0]     ready_mask;
      logic [MASK_W-1:0]     present_mask;
      logic [OCC_W-1:0]      occupancy;
      logic [BYTES_W-1:0]    packet_bytes;
      logic                  at_head;
      logic [CH_FIELD_W-1:0] channel;
      logic [ELAPSED_W-1:0]  elapsed;
   } attempt_type;

   // One verdict, again with the first field in the lowest bits.
   typedef struct packed {
      logic                  grant_valid;
      logic [CH_FIELD_W-1:0] granted_channel;
      logic [BYTES_W-1:0]    xfer_latency;
      logic [DELAY_W-1:0]    retry_delay;
      outcome_type           outcome;
   } verdict_type;

   localparam int ATTEMPT_W = $bits(attempt_type);
   localparam int VERDICT_W = $bits(verdict_type);

   // The stimulus stream mixes attempts and register writes in program order.
   typedef struct {
      logic                   is_write;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      attempt_type            attempt;
   } link_op_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   link_op_type link_ops[$];
   verdict_type verdict_queue[$];

   // Handshake flags registered at the rising edge for the falling-edge drivers.
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Driver bookkeeping: what is on the bus and how long each side holds off.
   logic req_on = 1'b0;
   logic csr_on = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   calm_req = 0;
   int   calm_rsp = 0;

   int error_count = 0;
   int cycle_count = 0;

   // Predicted register file and timing state of the arbiter.
   logic [BW_W-1:0]  link_bw;
   logic [CAP_W-1:0] dest_cap;
   logic [CIU_W-1:0] vc_count;
   logic [31:0]      now_cycle;
   logic [31:0]      link_busy_end;
   logic [31:0]      read_busy_end[MAX_VC];
   logic [31:0]      write_busy_end[MAX_VC];
   logic [1:0]       rr_last;
   logic [31:0]      memo_cycle;
   logic [2:0]       memo_pick;    // granted channel + 1, zero for none

   link_vc_arbiter_transfer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Wait draw shared by both sides, with occasional calm stretches in which
   // the side never holds off.
   function automatic int draw_wait(inout int calm);
      int w;
      if (calm > 0) begin
         calm--;
         w = 0;
      end else begin
         if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
         w = $urandom_range(0, 4);
      end
      return w;
   endfunction

   // Retry delay toward a busy end time, saturating at the field maximum.
   function automatic logic [DELAY_W-1:0] clip_delay(logic [31:0] until_t);
      logic [31:0] diff;
      diff = until_t - now_cycle;
      if (diff >= 32'(DELAY_SAT_DIFF)) return DELAY_MAX;
      return DELAY_W'(diff + 32'd1);
   endfunction

   // Advances the predicted clock by the attempt's elapsed cycles and judges
   // the attempt in the block's order: channel, head, link, arbitration,
   // destination write side, destination room.
   function automatic verdict_type judge_attempt(attempt_type a);
      verdict_type r;
      int          n;
      int          i;
      int          idx;
      logic [2:0]  pick;
      logic [BW_W-1:0] bw;
      logic [BYTES_W-1:0] lat;
      logic [31:0] end_t;
      r = '0;
      r.outcome = OUT_SENT;
      // Out-of-range channel counts are clamped into 1..MAX_VC.
      if (vc_count == 0) n = 1;
      else if (int'(vc_count) > MAX_VC) n = MAX_VC;
      else n = int'(vc_count);
      now_cycle = now_cycle + 32'(a.elapsed);
      if (int'(a.channel) >= n) begin
         r.outcome = OUT_BAD_CHANNEL;
      end else if (!a.at_head) begin
         r.outcome = OUT_NOT_HEAD;
      end else if (link_busy_end >= now_cycle) begin
         r.outcome = OUT_LINK_BUSY;
         r.retry_delay = clip_delay(link_busy_end);
      end else begin
         // Arbitration is decided once per cycle; later attempts in the same
         // cycle see the same pick.
         if (memo_cycle == now_cycle) begin
            pick = memo_pick;
         end else begin
            memo_cycle = now_cycle;
            pick = 3'd0;
            for (i = 0; i < n; i++) begin
               idx = (int'(rr_last) + i + 1) % n;
               if (pick == 3'd0 && a.present_mask[idx] && a.ready_mask[idx] &&
                   !(read_busy_end[idx] >= now_cycle)) begin
                  pick = 3'(idx + 1);
                  rr_last = 2'(idx);
               end
            end
            memo_pick = pick;
         end
         if (pick != 3'd0) begin
            r.grant_valid = 1'b1;
            r.granted_channel = 2'(pick - 3'd1);
         end
         if (int'(pick) != int'(a.channel) + 1) begin
            r.outcome = OUT_ARB_LOST;
            r.retry_delay = DELAY_W'(1);
         end else if (write_busy_end[a.channel] >= now_cycle) begin
            r.outcome = OUT_DEST_BUSY;
            r.retry_delay = clip_delay(write_busy_end[a.channel]);
         end else if (int'(a.occupancy) + int'(a.packet_bytes) > int'(dest_cap)) begin
            r.outcome = OUT_DEST_FULL;
         end else begin
            // Zero bandwidth acts as a bandwidth of one; an empty packet
            // gets the latency of a one-byte packet.
            bw = (link_bw == 0) ? BW_W'(1) : link_bw;
            if (a.packet_bytes == 0) lat = BYTES_W'(1);
            else lat = BYTES_W'((int'(a.packet_bytes) - 1) / int'(bw) + 1);
            end_t = now_cycle + 32'(lat) - 32'd1;
            read_busy_end[a.channel] = end_t;
            write_busy_end[a.channel] = end_t;
            link_busy_end = end_t;
            r.xfer_latency = lat;
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic add_attempt(logic [ELAPSED_W-1:0] el, logic [CH_FIELD_W-1:0] ch,
                              logic head, logic [BYTES_W-1:0] bytes,
                              logic [OCC_W-1:0] occ, logic [MASK_W-1:0] pres,
                              logic [MASK_W-1:0] rdy);
      link_op_type op;
      op.is_write = 1'b0;
      op.reg_index = '0;
      op.reg_value = '0;
      op.attempt = '{ready_mask: rdy, present_mask: pres, occupancy: occ,
                     packet_bytes: bytes, at_head: head, channel: ch, elapsed: el};
      link_ops.push_back(op);
   endtask

   task automatic add_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      link_op_type op;
      op.is_write = 1'b1;
      op.reg_index = idx;
      op.reg_value = value;
      op.attempt = '0;
      link_ops.push_back(op);
   endtask

   // Sender side: attempts and register writes leave the op stream in order.
   // A register write is held back until every outstanding verdict has come
   // back, so the block is idle when its settings change. After each
   // attempt or register write the sender holds off for a drawn wait.
   always @(negedge clock) begin : stim_driver
      link_op_type op;
      if (!reset) begin
         if (req_taken) req_on = 1'b0;
         if (csr_taken) csr_on = 1'b0;
         if (!req_on && !csr_on) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (link_ops.size() != 0) begin
               if (!link_ops[0].is_write) begin
                  op = link_ops.pop_front();
                  req_on = 1'b1;
                  req_tdata <= REQ_DATA_W'(op.attempt);
                  gap_left = draw_wait(calm_req);
               end else if (verdict_queue.size() == 0) begin
                  op = link_ops.pop_front();
                  csr_on = 1'b1;
                  csr_index <= op.reg_index;
                  csr_wdata <= op.reg_value;
                  gap_left = draw_wait(calm_req);
               end
            end
         end
      end
      req_tvalid <= req_on;
      csr_valid <= csr_on;
   end

   // Receiver side: after each accepted result it stalls a drawn number of
   // cycles, so back-pressure holds results and stalls the block's done step.
   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) stall_left = draw_wait(calm_rsp);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Everything that happens at a rising edge: register writes update the
   // predicted settings, results are checked against the oldest verdict, and
   // accepted attempts are judged. Results are checked before the attempt of
   // the same edge is queued; a result can never belong to that attempt.
   always @(posedge clock) begin : xfer_monitor
      verdict_type seen;
      verdict_type want;
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
         rsp_taken <= 1'b0;
         link_bw = BW_RESET;
         dest_cap = CAP_RESET;
         vc_count = CIU_RESET;
         now_cycle = 32'd1;
         link_busy_end = '0;
         for (int c = 0; c < MAX_VC; c++) begin
            read_busy_end[c] = '0;
            write_busy_end[c] = '0;
         end
         rr_last = '0;
         memo_cycle = '0;
         memo_pick = '0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         csr_taken <= csr_valid && csr_ready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINK_BW:    link_bw = csr_wdata[BW_W-1:0];
               CSR_DEST_BYTES: dest_cap = csr_wdata[CAP_W-1:0];
               CSR_CHANNELS:   vc_count = csr_wdata[CIU_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = verdict_type'(rsp_tdata[VERDICT_W-1:0]);
            if (verdict_queue.size() == 0) begin
               $display("%0t: result expected none, actual 0x%h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = verdict_queue.pop_front();
               check_field("outcome", int'(want.outcome), int'(seen.outcome));
               check_field("retry_delay", int'(want.retry_delay), int'(seen.retry_delay));
               check_field("transfer_latency", int'(want.xfer_latency),
                           int'(seen.xfer_latency));
               check_field("granted_channel", int'(want.granted_channel),
                           int'(seen.granted_channel));
               check_field("grant_valid", int'(want.grant_valid), int'(seen.grant_valid));
            end
         end
         if (req_tvalid && req_tready)
            verdict_queue.push_back(judge_attempt(attempt_type'(req_tdata[ATTEMPT_W-1:0])));
      end
   end

   // Runaway guard: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("link_vc_arbiter_transfer: mismatch");
      $finish;
   end

   initial begin : scenario
      int k;
      int phase;
      int n_eff;
      int el;
      int ch;
      int head;
      int bytes;
      int occ;
      logic [MASK_W-1:0] pres;
      logic [MASK_W-1:0] rdy;
      logic [CSR_DATA_W-1:0] bw_raw;
      logic [CSR_DATA_W-1:0] cap_raw;
      logic [CSR_DATA_W-1:0] ciu_raw;

      // Directed part at the reset settings: 8 bytes per cycle, 1024-byte
      // buffers, one channel. The cycle count starts at one.
      add_attempt(0, 3, 1, 64, 0, 4'hF, 4'hF);       // channel beyond the count
      add_attempt(5, 1, 1, 64, 0, 4'hF, 4'hF);       // first channel beyond the count
      add_attempt(1, 0, 0, 64, 0, 4'hF, 4'hF);       // packet not at its head
      add_attempt(1, 0, 1, 64, 0, 4'h0, 4'hF);       // no head present, nobody wins
      add_attempt(0, 0, 1, 64, 0, 4'hF, 4'hF);       // same cycle reuses the empty pick
      add_attempt(1, 0, 1, 1024, 0, 4'hF, 4'hF);     // full-size transfer
      add_attempt(0, 0, 1, 8, 0, 4'hF, 4'hF);        // link still busy
      add_attempt(255, 0, 1, 0, 0, 4'hF, 4'hF);      // zero-size packet
      add_attempt(2, 0, 1, 2047, 16'hFFFF, 4'hF, 4'hF); // largest fields, buffer full
      add_attempt(1, 0, 1, 1000, 24, 4'hF, 4'hF);    // exactly fills the buffer
      add_attempt(255, 0, 1, 1, 1024, 4'hF, 4'hE);   // head busy, arbitration lost
      add_attempt(1, 0, 1, 1, 1024, 4'hF, 4'hF);     // one byte over capacity

      // Four channels at one byte per cycle: a transfer of the largest size, then
      // a retry delay at its saturation point.
      add_write(CSR_CHANNELS, 16'd4);
      add_write(CSR_LINK_BW, 16'd1);
      add_write(CSR_DEST_BYTES, 16'hFFFF);
      add_attempt(1, 2, 1, 2047, 0, 4'b0100, 4'b0100);
      add_attempt(0, 1, 1, 5, 0, 4'hF, 4'hF);

      // At a bandwidth of 64, wait the link out; round-robin then moves on
      // from channel 2 to 3 and wraps to 0.
      add_write(CSR_LINK_BW, 16'd64);
      for (k = 0; k < 9; k++) add_attempt(255, 3, 1, 64, 0, 4'hF, 4'hF);
      add_attempt(1, 0, 1, 64, 0, 4'hF, 4'hF);

      // Random phases, each under its own settings, extremes included.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin bw_raw = 16'd64; cap_raw = 16'hFFFF; ciu_raw = 16'd4; end
            1: begin bw_raw = 16'd1; cap_raw = 16'd4096; ciu_raw = 16'd2; end
            2: begin bw_raw = 16'd0; cap_raw = 16'd1; ciu_raw = 16'd7; end
            3: begin bw_raw = 16'hFFFF; cap_raw = 16'd1024; ciu_raw = 16'hFFF8; end
            4: begin
               bw_raw = 16'($urandom_range(1, 64));
               cap_raw = 16'($urandom);
               ciu_raw = 16'd3;
            end
            5: begin bw_raw = 16'd8; cap_raw = 16'd1024; ciu_raw = 16'd1; end
            default: begin
               bw_raw = 16'($urandom);
               cap_raw = 16'($urandom);
               ciu_raw = 16'd4;
            end
         endcase
         add_write(CSR_LINK_BW, bw_raw);
         add_write(CSR_DEST_BYTES, cap_raw);
         add_write(CSR_CHANNELS, ciu_raw);
         if (phase == 4) add_write(CSR_SPARE, 16'($urandom));
         if (ciu_raw[CIU_W-1:0] == 0) n_eff = 1;
         else if (int'(ciu_raw[CIU_W-1:0]) > MAX_VC) n_eff = MAX_VC;
         else n_eff = int'(ciu_raw[CIU_W-1:0]);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            // Mostly well-formed attempts from an active channel whose head
            // is present; elapsed cycles lean toward zero and short steps so
            // that same-cycle arbitration and busy links come up often.
            ch = $urandom_range(0, n_eff - 1);
            head = 1;
            case ($urandom_range(0, 3))
               0: el = 0;
               1: el = $urandom_range(1, 15);
               2: el = $urandom_range(16, 80);
               default: el = $urandom_range(0, 255);
            endcase
            if ($urandom_range(0, 3) == 0) bytes = $urandom_range(0, 2047);
            else bytes = $urandom_range(1, 512);
            if ($urandom_range(0, 1) == 1 && int'(cap_raw) > bytes)
               occ = $urandom_range(0, int'(cap_raw) - bytes);
            else
               occ = $urandom_range(0, 65535);
            pres = 4'($urandom);
            rdy = 4'($urandom);
            case ($urandom_range(0, 2))
               0: begin pres = 4'(1 << ch); rdy = 4'(1 << ch); end
               1: begin pres = pres | 4'(1 << ch); rdy = rdy | 4'(1 << ch); end
               default: ;
            endcase
            // A fifth of the attempts draw channel, head, size and occupancy over their whole ranges.
            if ($urandom_range(0, 9) < 2) begin
               ch = $urandom_range(0, 3);
               head = $urandom_range(0, 1);
               bytes = $urandom_range(0, 2047);
               occ = $urandom_range(0, 65535);
            end
            add_attempt(el, ch, head, bytes, occ, pres, rdy);
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Drain: all ops sent, nothing on the bus, every verdict returned.
      while (link_ops.size() != 0 || req_on || csr_on || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("link_vc_arbiter_transfer: match");
      end else begin
         $display("link_vc_arbiter_transfer: mismatch");
      end
      $finish;
   end

endmodule
